FILE: rtl/rti_pkg.sv
// package for the ray / triangle hit test pipeline
// holds coordinate widths, derived arithmetic widths and register indexes
`default_nettype none
package rti_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int POINT_WIDTH = 48;
    localparam int CFG_WIDTH   = 32;
    // difference of two coordinates
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    // product of two differences
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    // cross product component
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    // product of difference and cross component
    localparam int TRI_WIDTH   = DIFF_WIDTH + CROSS_WIDTH;
    // dot product result
    localparam int DOT_WIDTH   = TRI_WIDTH + 2;

    localparam logic CFG_DET_EPSILON = 1'b0;
    localparam logic CFG_T_EPSILON   = 1'b1;
    localparam int   CFG_IDX_WIDTH   = 1;

    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;
    typedef logic signed [TRI_WIDTH-1:0]   tri_t;
    typedef logic signed [DOT_WIDTH-1:0]   dot_t;

    // sign-extended lane k of a packed point
    function automatic diff_t lane(input logic [POINT_WIDTH-1:0] p, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = p[k*COORD_WIDTH +: COORD_WIDTH];
        return diff_t'(c);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/ray_triangle_intersect.sv
// ray / triangle hit test, Moller-Trumbore without division
// throughput: one word per cycle
// every stage is a register level; the receiver cannot stall, so busy is held low
// reset: rst_n clears all valid bits, det_epsilon to 1 and t_epsilon to 0
// uses rti_pkg
`default_nettype none
module ray_triangle_intersect (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rti_pkg::POINT_WIDTH-1:0] ray_from,
    input  wire logic [rti_pkg::POINT_WIDTH-1:0] ray_to,
    input  wire logic [rti_pkg::POINT_WIDTH-1:0] tri_a,
    input  wire logic [rti_pkg::POINT_WIDTH-1:0] tri_b,
    input  wire logic [rti_pkg::POINT_WIDTH-1:0] tri_c,
    input  wire logic                           cfg_we,
    input  wire logic [7:0]                     cfg_index,
    input  wire logic [rti_pkg::CFG_WIDTH-1:0]   cfg_data,
    output logic                                done,
    output logic                                hit
);
    import rti_pkg::*;

    logic [CFG_WIDTH-1:0] det_eps_reg, t_eps_reg;
    logic [5:0] vld_reg;

    // stage 1 words: differences
    diff_t dir_reg[3], e1_reg[3], e2_reg[3], tv_reg[3];
    // stage 2: cross products as separate products
    prod_t pp_reg[6], qp_reg[6];
    diff_t dir2_reg[3], e12_reg[3], e22_reg[3], tv2_reg[3];
    // stage 3: cross components
    cross_t pv_reg[3], qv_reg[3];
    diff_t dir3_reg[3], e13_reg[3], e23_reg[3], tv3_reg[3];
    // stage 4: dot terms
    tri_t dt_reg[3], ut_reg[3], vt_reg[3], tt_reg[3];
    // stage 5: dot sums and sign correction
    logic [DOT_WIDTH-1:0] adet_reg;
    dot_t un_reg, vn_reg, tn_reg;
    // stage 6 output
    logic hit_reg;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_eps_reg <= CFG_WIDTH'(1);
            t_eps_reg   <= '0;
        end
        else if (cfg_we && cfg_index[7:CFG_IDX_WIDTH] == '0)
        begin
            if (cfg_index[0] == CFG_DET_EPSILON)
                det_eps_reg <= cfg_data;
            else
                t_eps_reg <= cfg_data;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[4:0], start};
    end

    // dot sums and sign correction
    dot_t det_sum, un_sum, vn_sum, tn_sum;
    logic det_neg;
    always_comb
    begin
        det_sum = dot_t'(dt_reg[0]) + dot_t'(dt_reg[1]) + dot_t'(dt_reg[2]);
        un_sum  = dot_t'(ut_reg[0]) + dot_t'(ut_reg[1]) + dot_t'(ut_reg[2]);
        vn_sum  = dot_t'(vt_reg[0]) + dot_t'(vt_reg[1]) + dot_t'(vt_reg[2]);
        tn_sum  = dot_t'(tt_reg[0]) + dot_t'(tt_reg[1]) + dot_t'(tt_reg[2]);
        det_neg = det_sum[DOT_WIDTH-1];
    end

    // final compares
    logic hit_next;
    dot_t uv_sum, adet_s;
    always_comb
    begin
        adet_s = dot_t'(adet_reg);
        uv_sum = un_reg + vn_reg;
        hit_next = (adet_reg >= DOT_WIDTH'(det_eps_reg))
                && !un_reg[DOT_WIDTH-1] && (un_reg <= adet_s)
                && !vn_reg[DOT_WIDTH-1] && (uv_sum <= adet_s)
                && (tn_reg > dot_t'({1'b0, t_eps_reg}));
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            // stage 1
            dir_reg[k] <= lane(ray_to, k) - lane(ray_from, k);
            e1_reg[k]  <= lane(tri_b, k) - lane(tri_a, k);
            e2_reg[k]  <= lane(tri_c, k) - lane(tri_a, k);
            tv_reg[k]  <= lane(ray_from, k) - lane(tri_a, k);
            // stage 2
            pp_reg[2*k]   <= prod_t'(dir_reg[(k+1)%3]) * prod_t'(e2_reg[(k+2)%3]);
            pp_reg[2*k+1] <= prod_t'(dir_reg[(k+2)%3]) * prod_t'(e2_reg[(k+1)%3]);
            qp_reg[2*k]   <= prod_t'(tv_reg[(k+1)%3]) * prod_t'(e1_reg[(k+2)%3]);
            qp_reg[2*k+1] <= prod_t'(tv_reg[(k+2)%3]) * prod_t'(e1_reg[(k+1)%3]);
            dir2_reg[k] <= dir_reg[k];
            e12_reg[k]  <= e1_reg[k];
            e22_reg[k]  <= e2_reg[k];
            tv2_reg[k]  <= tv_reg[k];
            // stage 3
            pv_reg[k] <= cross_t'(pp_reg[2*k]) - cross_t'(pp_reg[2*k+1]);
            qv_reg[k] <= cross_t'(qp_reg[2*k]) - cross_t'(qp_reg[2*k+1]);
            dir3_reg[k] <= dir2_reg[k];
            e13_reg[k]  <= e12_reg[k];
            e23_reg[k]  <= e22_reg[k];
            tv3_reg[k]  <= tv2_reg[k];
            // stage 4
            dt_reg[k] <= tri_t'(e13_reg[k]) * tri_t'(pv_reg[k]);
            ut_reg[k] <= tri_t'(tv3_reg[k]) * tri_t'(pv_reg[k]);
            vt_reg[k] <= tri_t'(dir3_reg[k]) * tri_t'(qv_reg[k]);
            tt_reg[k] <= tri_t'(e23_reg[k]) * tri_t'(qv_reg[k]);
        end
        // stage 5
        adet_reg <= det_neg ? DOT_WIDTH'(-det_sum) : DOT_WIDTH'(det_sum);
        un_reg   <= det_neg ? -un_sum : un_sum;
        vn_reg   <= det_neg ? -vn_sum : vn_sum;
        tn_reg   <= det_neg ? -tn_sum : tn_sum;
        // stage 6
        hit_reg  <= hit_next;
    end

    assign done = vld_reg[5];
    assign hit  = hit_reg;

`ifndef NO_ASSERTIONS
    // a result word follows every start after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##6 done) else $error("missing result word");
    // no result word without an earlier start
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6)) else $error("spurious result word");
    // a result never hits with zero det while det_epsilon is nonzero
    a_det_reject: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && adet_reg == '0 && det_eps_reg != '0 |=> !hit)
        else $error("hit with zero determinant");
`endif
endmodule
`default_nettype wire

FILE: tb/ray_triangle_intersect_tb.sv
// self-checking testbench for the ray / triangle hit test pipeline
// holds a scoreboard class, an exact integer hit predictor and the stimulus tasks
// depends on rti_pkg and ray_triangle_intersect
`default_nettype none
module ray_triangle_intersect_tb;
    import rti_pkg::*;

    typedef logic [POINT_WIDTH-1:0] point_t;
    typedef logic [CFG_WIDTH-1:0]   reg_t;

    localparam logic [7:0] IDX_DET_EPS = 8'(CFG_DET_EPSILON);
    localparam logic [7:0] IDX_T_EPS   = 8'(CFG_T_EPSILON);
    // index that decodes to no register
    localparam logic [7:0] IDX_UNUSED  = 8'hA5;
    localparam int PIPE_DEPTH  = 6;
    localparam int STALL_LIMIT = 5000;

    // queue of expected hit bits, checked in order
    class hit_scoreboard;
        bit pending[$];
        int mismatches;
        int checked;
        int hits;
        int unexpected;

        function void note_word(bit want);
            pending = {pending, want};
        endfunction

        function void check_word(bit got);
            bit want;
            if (pending.size() == 0)
            begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: hit=%0b", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got)
                hits++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("hit mismatch on word %0d: expected %0b, got %0b",
                             checked, want, got);
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    point_t ray_from, ray_to, tri_a, tri_b, tri_c;
    logic   cfg_we;
    logic [7:0] cfg_index;
    reg_t   cfg_data;
    logic   done;
    logic   hit;

    hit_scoreboard sb;
    reg_t det_eps_model;
    reg_t t_eps_model;
    int   sent_count;
    int   stall_cycles;

    ray_triangle_intersect dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ray_from(ray_from), .ray_to(ray_to),
        .tri_a(tri_a), .tri_b(tri_b), .tri_c(tri_c),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // signed coordinate of lane k
    function automatic longint coord(point_t p, int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = p[k*COORD_WIDTH +: COORD_WIDTH];
        return longint'(c);
    endfunction

    // Moller-Trumbore test on exact integers, division replaced by |det| bounds
    function automatic bit predict_hit(point_t f, point_t t, point_t a, point_t b,
                                       point_t c, reg_t det_eps, reg_t t_eps);
        longint dir[3], e1[3], e2[3], tv[3], pv[3], qv[3];
        longint det, adet, un, vn, tn;
        bit neg;
        for (int k = 0; k < 3; k++)
        begin
            dir[k] = coord(t, k) - coord(f, k);
            e1[k]  = coord(b, k) - coord(a, k);
            e2[k]  = coord(c, k) - coord(a, k);
            tv[k]  = coord(f, k) - coord(a, k);
        end
        pv[0] = dir[1] * e2[2] - dir[2] * e2[1];
        pv[1] = dir[2] * e2[0] - dir[0] * e2[2];
        pv[2] = dir[0] * e2[1] - dir[1] * e2[0];
        qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
        qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
        qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
        det  = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
        neg  = det < 0;
        adet = neg ? -det : det;
        // parallel ray
        if (adet < longint'(det_eps))
            return 1'b0;
        un = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
        vn = dir[0] * qv[0] + dir[1] * qv[1] + dir[2] * qv[2];
        tn = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
        if (neg)
        begin
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        if (un < 0 || un > adet)
            return 1'b0;
        if (vn < 0 || un + vn > adet)
            return 1'b0;
        return tn > longint'(t_eps);
    endfunction

    function automatic point_t pt(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic int rand_coord(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // fully random point, upper bits dropped
    function automatic point_t rand_point();
        return point_t'({$urandom, $urandom});
    endfunction

    // one word: random gap, then hold start until accepted
    task automatic send_word(point_t f, point_t t, point_t a, point_t b, point_t c);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 9));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        ray_from <= f;
        ray_to   <= t;
        tri_a    <= a;
        tri_b    <= b;
        tri_c    <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(predict_hit(f, t, a, b, c, det_eps_model, t_eps_model));
        sent_count++;
    endtask

    // stop sending and wait until every pending word is back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, reg_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == IDX_DET_EPS)
            det_eps_model = value;
        else if (idx == IDX_T_EPS)
            t_eps_model = value;
        @(posedge clk);
    endtask

    // ray aimed near the centroid of a random triangle, size picked per word
    task automatic send_aimed();
        int r, jit;
        int ax, ay, az, bx, by, bz, cx, cy, cz;
        int tx, ty, tz;
        case ($urandom_range(0, 9)) inside
            [0:3]:   r = 100;
            [4:7]:   r = 2000;
            default: r = 16383;
        endcase
        jit = $urandom_range(0, 1) ? 0 : r / 2;
        ax = rand_coord(r); ay = rand_coord(r); az = rand_coord(r);
        bx = rand_coord(r); by = rand_coord(r); bz = rand_coord(r);
        cx = rand_coord(r); cy = rand_coord(r); cz = rand_coord(r);
        tx = (ax + bx + cx) / 3 + rand_coord(jit);
        ty = (ay + by + cy) / 3 + rand_coord(jit);
        tz = (az + bz + cz) / 3 + rand_coord(jit);
        send_word(pt(rand_coord(r), rand_coord(r), rand_coord(r)), pt(tx, ty, tz),
                  pt(ax, ay, az), pt(bx, by, bz), pt(cx, cy, cz));
    endtask

    task automatic send_noise();
        send_word(rand_point(), rand_point(), rand_point(), rand_point(), rand_point());
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_aimed();
    endtask

    task automatic directed_words();
        point_t a, b, c;
        a = pt(0, 0, 0);
        b = pt(100, 0, 0);
        c = pt(0, 100, 0);
        // plain hit, miss outside, ray pointing away, hit through a vertex
        send_word(pt(10, 10, -50), pt(10, 10, 50), a, b, c);
        send_word(pt(90, 90, -50), pt(90, 90, 50), a, b, c);
        send_word(pt(10, 10, -50), pt(10, 10, -100), a, b, c);
        send_word(pt(0, 0, -50), pt(0, 0, 50), a, b, c);
        // point on an edge, negative det by swapped winding
        send_word(pt(50, 50, -50), pt(50, 50, 50), a, b, c);
        send_word(pt(10, 10, -50), pt(10, 10, 50), a, c, b);
        // ray in the plane, zero direction, degenerate triangle
        send_word(pt(-10, 10, 0), pt(200, 10, 0), a, b, c);
        send_word(pt(10, 10, 5), pt(10, 10, 5), a, b, c);
        send_word(pt(10, 10, -50), pt(10, 10, 50), a, b, b);
        // start on the plane: t numerator zero
        send_word(pt(10, 10, 0), pt(10, 10, 50), a, b, c);
        // coordinate extremes
        send_word(pt(-32768, -32768, -32768), pt(32767, 32767, 32767),
                  pt(32767, -32768, 0), pt(-32768, 32767, 0), pt(0, 0, 32767));
        send_word(pt(0, 0, -32768), pt(0, 0, 32767),
                  pt(-32768, -32768, 0), pt(32767, -32768, 0), pt(0, 32767, 0));
        send_word('1, '0, '1, '0, '1);
        send_word('0, '1, '0, '1, '0);
        send_word('1, '1, '1, '1, '1);
    endtask

    // cycles with no accepted word and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && done)
            sb.check_word(hit);

    initial
    begin
        sb = new();
        sent_count   = 0;
        stall_cycles = 0;
        det_eps_model = 32'd1;
        t_eps_model   = 32'd0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        ray_from  <= '0;
        ray_to    <= '0;
        tri_a     <= '0;
        tri_b     <= '0;
        tri_c     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        directed_words();
        random_phase(120);
        drain();

        // zero epsilons: a zero det is no longer parallel
        write_reg(IDX_DET_EPS, 32'd0);
        write_reg(IDX_T_EPS, 32'd0);
        write_reg(IDX_UNUSED, 32'hFFFF_FFFF);
        send_word(pt(10, 10, 5), pt(10, 10, 5), pt(0, 0, 0), pt(100, 0, 0),
                  pt(0, 100, 0));
        send_word(pt(-10, 10, 0), pt(200, 10, 0), pt(0, 0, 0), pt(100, 0, 0),
                  pt(0, 100, 0));
        random_phase(120);
        drain();

        write_reg(IDX_DET_EPS, 32'd5000);
        write_reg(IDX_T_EPS, 32'd100000);
        random_phase(120);
        drain();

        // largest thresholds
        write_reg(IDX_DET_EPS, 32'hFFFF_FFFF);
        write_reg(IDX_T_EPS, 32'd0);
        random_phase(30);
        drain();
        write_reg(IDX_DET_EPS, 32'd1);
        write_reg(IDX_T_EPS, 32'hFFFF_FFFF);
        random_phase(40);
        drain();

        write_reg(IDX_DET_EPS, $urandom_range(0, 1 << 20));
        write_reg(IDX_T_EPS, $urandom_range(0, 1 << 24));
        random_phase(100);
        drain();

        $display("sent %0d words over six register settings, %0d results checked, %0d hits",
                 sent_count, sb.checked, sb.hits);
        $display("%0d mismatches, %0d results with nothing pending",
                 sb.mismatches, sb.unexpected);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/rti_pkg.sv
rtl/ray_triangle_intersect.sv
tb/ray_triangle_intersect_tb.sv
